[design/png_chunk_stream_validator_unit_assert.svh]
// assertion macros for the png chunk validator
`ifndef PNG_CHUNK_STREAM_VALIDATOR_UNIT_ASSERT_SVH
`define PNG_CHUNK_STREAM_VALIDATOR_UNIT_ASSERT_SVH
// implication checked on every clock unless reset is low
`define PCV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PCV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[design/pcv_pkg.sv]
// package with phase codes, constants and check functions of the png validator
package pcv_pkg;
  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    VERDICT_REJECT  = 2'd0,
    VERDICT_PARTIAL = 2'd1,
    VERDICT_OK      = 2'd2
  } verdict_t;

  localparam int unsigned CFG_MAX_DIMENSION = 0;
  localparam int unsigned CFG_CHUNK_LIMIT   = 1;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned SIZE_W     = 48;

  localparam logic [31:0] KIND_IHDR = 32'h4948_4452;
  localparam logic [31:0] KIND_IDAT = 32'h4944_4154;
  localparam logic [31:0] KIND_IEND = 32'h4945_4E44;
  localparam logic [31:0] LEN_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] IHDR_LEN  = 32'd13;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [30:0] MAX_DIM_RESET   = 31'd100000;
  localparam logic [16:0] CHUNK_LIM_RESET = 17'd100000;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'h89;
      3'd1: r = 8'h50;
      3'd2: r = 8'h4E;
      3'd3: r = 8'h47;
      3'd4: r = 8'h0D;
      3'd5: r = 8'h0A;
      3'd6: r = 8'h1A;
      default: r = 8'h0A;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic alpha_byte(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic colour_ok(input logic [7:0] depth, input logic [7:0] colour);
    logic p2;
    logic r;
    p2 = (depth == 8'd1) || (depth == 8'd2) || (depth == 8'd4) || (depth == 8'd8);
    case (colour)
      8'd0: r = p2 || (depth == 8'd16);
      8'd3: r = p2;
      8'd2, 8'd4, 8'd6: r = (depth == 8'd8) || (depth == 8'd16);
      default: r = 1'b0;
    endcase
    return r;
  endfunction
endpackage

[design/pcv_in_if.sv]
// input and result channel interfaces of the png validator
interface pcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       first;
  logic       final_req;
  modport source (output valid, output file_byte, output first, output final_req,
                  input ready);
  modport sink (input valid, input file_byte, input first, input final_req,
                output ready);
endinterface

interface pcv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [47:0] file_size;
  modport source (output valid, output verdict, output file_size, input ready);
  modport sink (input valid, input verdict, input file_size, output ready);
endinterface

[design/png_chunk_stream_validator_unit.sv]
// png chunk stream validator top level
//
//  channel | dir | payload                        | beat taken when
//  in_     | in  | file_byte, first, final_req    | in_ch.valid & in_ch.ready
//  out_    | out | verdict, file_size             | out_ch.valid & out_ch.ready
//  cfg_    | in  | cfg_we, cfg_index, cfg_data    | cfg_we high
//
// one byte per cycle while the input is not stalled; a verdict appears in the cycle after the deciding beat
// the parse step is one pass of crc byte update and field compares
// rst_n synchronous, clears parser state and restores register defaults
// input stalls only while a verdict waits in the output register and is not taken
module png_chunk_stream_validator_unit #(
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pcv_in_if.sink                            in_ch,
  pcv_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pcv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcv_pkg::CFG_DATA_W-1:0]    cfg_data
);
`include "png_chunk_stream_validator_unit_assert.svh"

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // configuration
  logic [30:0] max_dim_r;
  logic [16:0] chunk_lim_r;

  // parser state
  pcv_pkg::phase_t           phase_r, phase_nxt;
  logic [POSITION_BITS-1:0]  pos_r, pos_nxt;
  logic [31:0]               fcnt_r, fcnt_nxt;
  logic [31:0]               len_r, len_nxt;
  logic [31:0]               kind_r, kind_nxt;
  logic [31:0]               crc_r, crc_nxt;
  logic [31:0]               scrc_r, scrc_nxt;
  logic [63:0]               hdr_r, hdr_nxt;
  logic [15:0]               dc_r, dc_nxt;
  logic                      seen_hdr_r, seen_hdr_nxt;
  logic                      seen_dat_r, seen_dat_nxt;
  logic [16:0]               walked_r, walked_nxt;
  logic                      decided_r, decided_nxt;

  // result register
  logic                        out_valid_r;
  logic [1:0]                  out_verdict_r;
  logic [pcv_pkg::SIZE_W-1:0]  out_size_r;

  logic                        take;
  logic                        emit;
  logic [1:0]                  verdict;
  logic [pcv_pkg::SIZE_W-1:0]  size;

  // output register frees as the waiting verdict is taken
  assign in_ch.ready    = !out_valid_r || out_ch.ready;
  assign take           = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.verdict = out_verdict_r;
  assign out_ch.file_size = out_size_r;

  always_comb begin
    logic                     dead;
    logic                     good;
    logic [31:0]              cnt1;
    logic [31:0]              kind_v;
    logic [31:0]              scrc_v;
    logic [31:0]              w;
    logic [31:0]              h;
    logic [1:0]               partial;
    // restart on first, otherwise carry state
    phase_nxt    = in_ch.first ? pcv_pkg::PH_SIG : phase_r;
    pos_nxt      = in_ch.first ? '0 : pos_r;
    fcnt_nxt     = in_ch.first ? '0 : fcnt_r;
    len_nxt      = in_ch.first ? '0 : len_r;
    kind_nxt     = in_ch.first ? '0 : kind_r;
    crc_nxt      = in_ch.first ? '1 : crc_r;
    scrc_nxt     = in_ch.first ? '0 : scrc_r;
    hdr_nxt      = in_ch.first ? '0 : hdr_r;
    dc_nxt       = in_ch.first ? '0 : dc_r;
    seen_hdr_nxt = in_ch.first ? 1'b0 : seen_hdr_r;
    seen_dat_nxt = in_ch.first ? 1'b0 : seen_dat_r;
    walked_nxt   = in_ch.first ? '0 : walked_r;
    decided_nxt  = in_ch.first ? 1'b0 : decided_r;
    dead    = decided_nxt;
    emit    = 1'b0;
    verdict = pcv_pkg::VERDICT_REJECT;
    size    = '0;
    good    = 1'b0;
    partial = pcv_pkg::VERDICT_REJECT;
    w       = hdr_nxt[63:32];
    h       = hdr_nxt[31:0];
    cnt1    = fcnt_nxt + 32'd1;
    kind_v  = {kind_nxt[23:0], in_ch.file_byte};
    scrc_v  = {scrc_nxt[23:0], in_ch.file_byte};
    if (!dead) begin
      if (pos_nxt != POS_MAX) begin
        pos_nxt = pos_nxt + 1'b1;
      end
      unique case (phase_nxt)
        pcv_pkg::PH_SIG: begin
          if (in_ch.file_byte != pcv_pkg::sig_byte(fcnt_nxt[2:0])) begin
            emit = 1'b1;
          end else if (cnt1 >= 32'd8) begin
            fcnt_nxt  = '0;
            len_nxt   = '0;
            phase_nxt = pcv_pkg::PH_LEN;
            if (chunk_lim_r == '0) begin
              emit = 1'b1;
            end
          end else begin
            fcnt_nxt = cnt1;
          end
        end
        pcv_pkg::PH_LEN: begin
          len_nxt = {len_nxt[23:0], in_ch.file_byte};
          if (cnt1 >= 32'd4) begin
            fcnt_nxt  = '0;
            kind_nxt  = '0;
            crc_nxt   = '1;
            phase_nxt = pcv_pkg::PH_TYPE;
          end else begin
            fcnt_nxt = cnt1;
          end
        end
        pcv_pkg::PH_TYPE: begin
          kind_nxt = kind_v;
          crc_nxt  = pcv_pkg::crc_byte(crc_nxt, in_ch.file_byte);
          if (cnt1 >= 32'd4) begin
            fcnt_nxt = '0;
            scrc_nxt = '0;
            if (len_nxt > pcv_pkg::LEN_MAX || !pcv_pkg::alpha_byte(kind_v[31:24]) ||
                !pcv_pkg::alpha_byte(kind_v[23:16]) || !pcv_pkg::alpha_byte(kind_v[15:8]) ||
                !pcv_pkg::alpha_byte(kind_v[7:0])) begin
              emit = 1'b1;
            end else if (!seen_hdr_nxt &&
                         (kind_v != pcv_pkg::KIND_IHDR || len_nxt != pcv_pkg::IHDR_LEN)) begin
              emit = 1'b1;
            end else begin
              phase_nxt = (len_nxt != '0) ? pcv_pkg::PH_DATA : pcv_pkg::PH_CRC;
            end
          end else begin
            fcnt_nxt = cnt1;
          end
        end
        pcv_pkg::PH_DATA: begin
          crc_nxt = pcv_pkg::crc_byte(crc_nxt, in_ch.file_byte);
          if (!seen_hdr_nxt) begin
            if (fcnt_nxt < 32'd8) begin
              hdr_nxt = {hdr_nxt[55:0], in_ch.file_byte};
            end else if (fcnt_nxt == 32'd8) begin
              dc_nxt = {in_ch.file_byte, dc_nxt[7:0]};
            end else if (fcnt_nxt == 32'd9) begin
              dc_nxt = {dc_nxt[15:8], in_ch.file_byte};
            end
          end
          if (cnt1 >= len_nxt) begin
            fcnt_nxt  = '0;
            phase_nxt = pcv_pkg::PH_CRC;
          end else begin
            fcnt_nxt = cnt1;
          end
        end
        pcv_pkg::PH_CRC: begin
          scrc_nxt = scrc_v;
          if (cnt1 >= 32'd4) begin
            good     = (~crc_nxt) == scrc_v;
            fcnt_nxt = '0;
            if (!seen_hdr_nxt) begin
              if (w == '0 || h == '0 || w > {1'b0, max_dim_r} || h > {1'b0, max_dim_r} ||
                  !pcv_pkg::colour_ok(dc_nxt[15:8], dc_nxt[7:0]) || !good) begin
                emit = 1'b1;
              end else begin
                seen_hdr_nxt = 1'b1;
              end
            end else if (kind_nxt == pcv_pkg::KIND_IEND) begin
              emit = 1'b1;
              if (len_nxt == '0 && good && seen_dat_nxt) begin
                verdict = pcv_pkg::VERDICT_OK;
                size    = pcv_pkg::SIZE_W'(pos_nxt);
              end
            end else if (kind_nxt == pcv_pkg::KIND_IDAT) begin
              seen_dat_nxt = 1'b1;
            end
            if (!emit) begin
              walked_nxt = walked_nxt + 17'd1;
              if (walked_nxt >= chunk_lim_r) begin
                emit    = 1'b1;
                verdict = (seen_hdr_nxt && seen_dat_nxt) ? pcv_pkg::VERDICT_PARTIAL
                                                         : pcv_pkg::VERDICT_REJECT;
              end else begin
                len_nxt   = '0;
                phase_nxt = pcv_pkg::PH_LEN;
              end
            end
          end else begin
            fcnt_nxt = cnt1;
          end
        end
        default: begin
          emit = 1'b1;
        end
      endcase
      partial = (seen_hdr_nxt && seen_dat_nxt) ? pcv_pkg::VERDICT_PARTIAL
                                               : pcv_pkg::VERDICT_REJECT;
      // truncation on the last available byte
      if (!emit && in_ch.final_req) begin
        emit    = 1'b1;
        verdict = partial;
      end
      if (emit) begin
        decided_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dim_r   <= pcv_pkg::MAX_DIM_RESET;
      chunk_lim_r <= pcv_pkg::CHUNK_LIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == pcv_pkg::CFG_IDX_W'(pcv_pkg::CFG_MAX_DIMENSION)) begin
        max_dim_r <= cfg_data;
      end else begin
        chunk_lim_r <= cfg_data[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pcv_pkg::PH_SIG;
      pos_r       <= '0;
      fcnt_r      <= '0;
      len_r       <= '0;
      kind_r      <= '0;
      crc_r       <= '1;
      scrc_r      <= '0;
      hdr_r       <= '0;
      dc_r        <= '0;
      seen_hdr_r  <= 1'b0;
      seen_dat_r  <= 1'b0;
      walked_r    <= '0;
      decided_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r    <= phase_nxt;
        pos_r      <= pos_nxt;
        fcnt_r     <= fcnt_nxt;
        len_r      <= len_nxt;
        kind_r     <= kind_nxt;
        crc_r      <= crc_nxt;
        scrc_r     <= scrc_nxt;
        hdr_r      <= hdr_nxt;
        dc_r       <= dc_nxt;
        seen_hdr_r <= seen_hdr_nxt;
        seen_dat_r <= seen_dat_nxt;
        walked_r   <= walked_nxt;
        decided_r  <= decided_nxt;
      end
      if (take && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload of the result register
  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_verdict_r <= verdict;
      out_size_r    <= size;
    end
  end

  `PCV_ASSERT_NEXT(a_emit_sets_valid, clk, rst_n, take && emit, out_valid_r, "verdict lost")
  `PCV_ASSERT_NEXT(a_emit_decides, clk, rst_n, take && emit, decided_r, "decided not set")
  `PCV_ASSERT_IMP(a_size_only_ok, clk, rst_n, out_valid_r && out_verdict_r != pcv_pkg::VERDICT_OK,
                  out_size_r == '0, "size without verified file")
  `PCV_ASSERT_IMP(a_no_emit_decided, clk, rst_n, take && decided_r && !in_ch.first, !emit,
                  "second verdict")
endmodule

[test/testbench.sv]
// byte-stream testbench for the png chunk stream validator with its own parser model
module testbench;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } file_beat_t;

  typedef struct packed {
    pcv_pkg::verdict_t verdict;
    logic [47:0]       size;
  } verdict_rec_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pcv_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pcv_pkg::CFG_DATA_W-1:0] cfg_data;

  pcv_in_if  in_ch ();
  pcv_out_if out_ch ();

  png_chunk_stream_validator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // beats waiting to be driven, verdicts waiting to be seen
  file_beat_t   beat_q[$];
  verdict_rec_t verdict_q[$];
  logic [7:0]   file_img[$];
  logic [7:0]   chunk_body[$];

  int  errors;
  int  beats_sent;
  int  verdicts_seen;
  int  files_sent;
  bit  idle_en;
  int  in_gap;
  int  out_hold;

  // parser model state and register copies
  logic [30:0]     lim_dim;
  logic [16:0]     lim_chunks;
  pcv_pkg::phase_t m_phase;
  logic [47:0]     m_pos;
  logic [31:0]     m_count;
  logic [31:0]     m_len;
  logic [31:0]     m_kind;
  logic [31:0]     m_crc;
  logic [31:0]     m_stored;
  logic [63:0]     m_hdr;
  logic [15:0]     m_dc;
  logic            m_seen_hdr;
  logic            m_seen_idat;
  logic [16:0]     m_walked;
  logic            m_done;

  function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
    return r;
  endfunction

  function automatic bit type_char_ok(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit depth_legal(input logic [7:0] d, input logic [7:0] c);
    bit low_pow;
    low_pow = (d == 8'd1) || (d == 8'd2) || (d == 8'd4) || (d == 8'd8);
    case (c)
      8'd0: return low_pow || d == 8'd16;
      8'd3: return low_pow;
      8'd2, 8'd4, 8'd6: return d == 8'd8 || d == 8'd16;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] sig_at(input int i);
    logic [7:0] s[8];
    s = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    return s[i];
  endfunction

  function automatic void parser_clear();
    m_phase = pcv_pkg::PH_SIG;
    m_pos = '0;
    m_count = '0;
    m_len = '0;
    m_kind = '0;
    m_crc = '1;
    m_stored = '0;
    m_hdr = '0;
    m_dc = '0;
    m_seen_hdr = 1'b0;
    m_seen_idat = 1'b0;
    m_walked = '0;
    m_done = 1'b0;
  endfunction

  // one byte through the parser; returns 1 when it decides the candidate
  function automatic bit png_verdict_step(input logic [7:0] b, input logic first_b,
                                          input logic last_b, output verdict_rec_t r);
    int vr;
    logic [31:0] w, h;
    bit good;
    vr = -1;
    r.size = '0;
    r.verdict = pcv_pkg::VERDICT_REJECT;
    if (first_b) parser_clear();
    if (m_done) return 1'b0;
    if (m_pos != 48'hFFFF_FFFF_FFFF) m_pos++;
    case (m_phase)
      pcv_pkg::PH_SIG: begin
        if (b != sig_at(m_count[2:0])) vr = 0;
        else begin
          m_count++;
          if (m_count >= 32'd8) begin
            m_count = '0;
            m_len = '0;
            m_phase = pcv_pkg::PH_LEN;
            if (lim_chunks == '0) vr = 0;
          end
        end
      end
      pcv_pkg::PH_LEN: begin
        m_len = {m_len[23:0], b};
        m_count++;
        if (m_count >= 32'd4) begin
          m_count = '0;
          m_kind = '0;
          m_crc = '1;
          m_phase = pcv_pkg::PH_TYPE;
        end
      end
      pcv_pkg::PH_TYPE: begin
        m_kind = {m_kind[23:0], b};
        m_crc = crc32_next(m_crc, b);
        m_count++;
        if (m_count >= 32'd4) begin
          m_count = '0;
          m_stored = '0;
          if (m_len > 32'h7FFF_FFFF || !type_char_ok(m_kind[31:24]) ||
              !type_char_ok(m_kind[23:16]) || !type_char_ok(m_kind[15:8]) ||
              !type_char_ok(m_kind[7:0]))
            vr = 0;
          else if (!m_seen_hdr && (m_kind != pcv_pkg::KIND_IHDR || m_len != 32'd13))
            vr = 0;
          else
            m_phase = (m_len != '0) ? pcv_pkg::PH_DATA : pcv_pkg::PH_CRC;
        end
      end
      pcv_pkg::PH_DATA: begin
        m_crc = crc32_next(m_crc, b);
        if (!m_seen_hdr) begin
          if (m_count < 32'd8) m_hdr = {m_hdr[55:0], b};
          else if (m_count == 32'd8) m_dc[15:8] = b;
          else if (m_count == 32'd9) m_dc[7:0] = b;
        end
        m_count++;
        if (m_count >= m_len) begin
          m_count = '0;
          m_phase = pcv_pkg::PH_CRC;
        end
      end
      default: begin
        m_stored = {m_stored[23:0], b};
        m_count++;
        if (m_count >= 32'd4) begin
          good = (m_crc ^ 32'hFFFF_FFFF) == m_stored;
          m_count = '0;
          if (!m_seen_hdr) begin
            w = m_hdr[63:32];
            h = m_hdr[31:0];
            if (w == '0 || h == '0 || w > {1'b0, lim_dim} || h > {1'b0, lim_dim} ||
                !depth_legal(m_dc[15:8], m_dc[7:0]) || !good)
              vr = 0;
            else
              m_seen_hdr = 1'b1;
          end else if (m_kind == pcv_pkg::KIND_IEND) begin
            if (m_len == '0 && good && m_seen_idat) begin
              vr = 2;
              r.size = m_pos;
            end else vr = 0;
          end else if (m_kind == pcv_pkg::KIND_IDAT) m_seen_idat = 1'b1;
          if (vr < 0) begin
            m_walked = m_walked + 17'd1;
            if (m_walked >= lim_chunks) vr = (m_seen_hdr && m_seen_idat) ? 1 : 0;
            else begin
              m_len = '0;
              m_phase = pcv_pkg::PH_LEN;
            end
          end
        end
      end
    endcase
    if (vr < 0 && last_b) vr = (m_seen_hdr && m_seen_idat) ? 1 : 0;
    if (vr < 0) return 1'b0;
    m_done = 1'b1;
    r.verdict = pcv_pkg::verdict_t'(vr[1:0]);
    return 1'b1;
  endfunction

  // clock, reset and time-zero input values
  initial begin
    clk = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.file_byte = '0;
    in_ch.first = 0;
    in_ch.final_req = 0;
    out_ch.ready = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  // byte driver: pops the pending beats, with random gaps while idle_en is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      in_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap != 0) begin
        in_ch.valid <= 0;
        in_gap <= in_gap - 1;
      end else if (beat_q.size() != 0) begin
        file_beat_t nb;
        nb = beat_q.pop_front();
        in_ch.valid <= 1;
        in_ch.file_byte <= nb.data;
        in_ch.first <= nb.first;
        in_ch.final_req <= nb.last;
        if (idle_en && $urandom_range(0, 6) == 0) in_gap <= $urandom_range(1, 3);
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // result side back-pressure, also in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
      out_hold <= 0;
    end else if (out_hold != 0) begin
      out_ch.ready <= 0;
      out_hold <= out_hold - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 0;
      out_hold <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1;
    end
  end

  // monitor: check verdict beats, then predict from accepted byte beats
  always @(posedge clk) begin : monitor
    verdict_rec_t got, want;
    if (!rst_n) begin
      parser_clear();
      verdict_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          errors++;
          $error("verdict beat with nothing expected: verdict %0d size %0d",
                 out_ch.verdict, out_ch.file_size);
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.verdict !== want.verdict) begin
            errors++;
            $error("verdict: expected %0d, got %0d", want.verdict, out_ch.verdict);
          end
          if (out_ch.file_size !== want.size) begin
            errors++;
            $error("file_size: expected %0d, got %0d", want.size, out_ch.file_size);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        beats_sent++;
        if (png_verdict_step(in_ch.file_byte, in_ch.first, in_ch.final_req, got))
          verdict_q.push_back(got);
      end
    end
  end

  // stimulus helpers
  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_img.push_back(w[i*8 +: 8]);
  endtask

  // chunk from chunk_body, crc over type and data, optionally spoiled
  task automatic add_chunk(input logic [31:0] kind, input bit bad_crc);
    logic [31:0] c;
    c = '1;
    put_word(32'(chunk_body.size()));
    for (int i = 3; i >= 0; i--) begin
      file_img.push_back(kind[i*8 +: 8]);
      c = crc32_next(c, kind[i*8 +: 8]);
    end
    foreach (chunk_body[i]) begin
      file_img.push_back(chunk_body[i]);
      c = crc32_next(c, chunk_body[i]);
    end
    c = c ^ 32'hFFFF_FFFF;
    if (bad_crc) c[$urandom_range(0, 31)] ^= 1'b1;
    put_word(c);
    chunk_body.delete();
  endtask

  task automatic add_ihdr(input logic [31:0] w, input logic [31:0] h,
                          input logic [7:0] d, input logic [7:0] c, input bit bad_crc);
    chunk_body.delete();
    for (int i = 3; i >= 0; i--) chunk_body.push_back(w[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) chunk_body.push_back(h[i*8 +: 8]);
    chunk_body.push_back(d);
    chunk_body.push_back(c);
    repeat (3) chunk_body.push_back(8'($urandom_range(0, 255)));
    add_chunk(pcv_pkg::KIND_IHDR, bad_crc);
  endtask

  task automatic start_file();
    file_img.delete();
    for (int i = 0; i < 8; i++) file_img.push_back(sig_at(i));
  endtask

  // queue the image; cut >= 0 stops there with final_req set
  task automatic send_file(input int cut, input bit final_on_last);
    int n;
    n = (cut >= 0 && cut < file_img.size()) ? cut + 1 : file_img.size();
    for (int i = 0; i < n; i++)
      beat_q.push_back('{file_img[i], i == 0,
                         (i == n - 1) && (cut >= 0 || final_on_last)});
    files_sent++;
  endtask

  function automatic logic [31:0] rand_kind();
    logic [31:0] k;
    for (int i = 0; i < 4; i++)
      k[i*8 +: 8] = $urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 25))
                                         : 8'(8'h61 + $urandom_range(0, 25));
    if ($urandom_range(0, 29) == 0)
      k[$urandom_range(0, 3)*8 +: 8] = 8'($urandom_range(0, 255));
    return k;
  endfunction

  // one random candidate, mostly well-formed with random content
  task automatic random_candidate();
    logic [31:0] w, h, top;
    logic [7:0]  d, c;
    int sel, nmid;
    if ($urandom_range(0, 19) == 0) begin
      // noise, sometimes with a plausible first byte
      file_img.delete();
      repeat ($urandom_range(1, 12)) file_img.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) file_img[0] = 8'h89;
      send_file(-1, 1'($urandom_range(0, 1)));
      return;
    end
    start_file();
    top = (lim_dim < 31'd64) ? {1'b0, lim_dim} : 32'd64;
    sel = $urandom_range(0, 11);
    w = (sel == 0) ? 32'd0 : (sel == 1) ? {1'b0, lim_dim} : (sel == 2) ? {1'b0, lim_dim} + 32'd1
                   : $urandom_range(1, top);
    sel = $urandom_range(0, 11);
    h = (sel == 0) ? 32'd0 : (sel == 1) ? {1'b0, lim_dim} : (sel == 2) ? {1'b0, lim_dim} + 32'd1
                   : $urandom_range(1, top);
    if ($urandom_range(0, 6) != 0) begin
      c = 8'(2 * $urandom_range(0, 3));
      if (c == 8'd0 && $urandom_range(0, 1)) c = 8'd3;
      d = (c == 8'd0 || c == 8'd3) ? 8'(1 << $urandom_range(0, (c == 8'd0) ? 4 : 3))
                                   : ($urandom_range(0, 1) ? 8'd8 : 8'd16);
    end else begin
      c = 8'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255));
      d = 8'($urandom_range(0, 1) ? $urandom_range(0, 16) : $urandom_range(0, 255));
    end
    add_ihdr(w, h, d, c, $urandom_range(0, 19) == 0);
    nmid = $urandom_range(0, 3);
    for (int k = 0; k < nmid; k++) begin
      repeat ($urandom_range(0, 4)) chunk_body.push_back(8'($urandom_range(0, 255)));
      add_chunk($urandom_range(0, 1) ? pcv_pkg::KIND_IDAT : rand_kind(),
                $urandom_range(0, 29) == 0);
    end
    if ($urandom_range(0, 15) == 0) begin
      // oversized or maximal declared length, cut short in its data
      put_word($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000 | $urandom);
      put_word(rand_kind());
      repeat (3) file_img.push_back(8'($urandom_range(0, 255)));
      send_file(file_img.size() - 1, 1);
      return;
    end
    if ($urandom_range(0, 9) == 0) chunk_body.push_back(8'($urandom_range(0, 255)));
    add_chunk(pcv_pkg::KIND_IEND, $urandom_range(0, 24) == 0);
    if ($urandom_range(0, 9) == 0)
      file_img[$urandom_range(0, file_img.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    repeat ($urandom_range(0, 3)) file_img.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 6) == 0) send_file($urandom_range(0, file_img.size() - 1), 1);
    else send_file(-1, 1'($urandom_range(0, 1)));
  endtask

  // block until the pipe is empty, then let the block idle before returning
  task automatic drain();
    int spins;
    spins = 0;
    while ((beat_q.size() != 0 || in_ch.valid || verdict_q.size() != 0) && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
    if (verdict_q.size() != 0) begin
      errors++;
      $error("%0d verdicts never arrived", verdict_q.size());
      verdict_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [30:0] val);
    cfg_we <= 1;
    cfg_index <= idx[pcv_pkg::CFG_IDX_W-1:0];
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == pcv_pkg::CFG_MAX_DIMENSION) lim_dim = val;
    else lim_chunks = val[16:0];
    @(posedge clk);
  endtask

  task automatic random_phase(input int n_beats);
    int goal;
    goal = beat_q.size() + beats_sent + n_beats;
    while (beats_sent + beat_q.size() < goal) begin
      random_candidate();
      // keep the pending queue short so gaps land on every parser phase
      while (beat_q.size() > 64) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    errors = 0;
    beats_sent = 0;
    verdicts_seen = 0;
    files_sent = 0;
    idle_en = 1;
    lim_dim = pcv_pkg::MAX_DIM_RESET;
    lim_chunks = pcv_pkg::CHUNK_LIM_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: bad signature, cut inside signature, oversized length,
    // first chunk not a header, then one minimal good file at the width limit
    beat_q.push_back('{8'h00, 1'b1, 1'b0});
    start_file();
    send_file(2, 1);
    start_file();
    put_word(32'h8000_0000);
    put_word(pcv_pkg::KIND_IHDR);
    send_file(-1, 0);
    start_file();
    put_word(32'd13);
    put_word(pcv_pkg::KIND_IDAT);
    send_file(-1, 0);
    start_file();
    add_ihdr({1'b0, lim_dim}, 32'd1, 8'd16, 8'd0, 0);
    add_chunk(pcv_pkg::KIND_IDAT, 0);
    add_chunk(pcv_pkg::KIND_IEND, 0);
    send_file(-1, 0);
    // sender holds off here until every verdict so far has come back
    drain();

    random_phase(370);
    write_reg(pcv_pkg::CFG_MAX_DIMENSION, 31'd1);
    write_reg(pcv_pkg::CFG_CHUNK_LIMIT, 31'd1);
    random_phase(300);
    write_reg(pcv_pkg::CFG_MAX_DIMENSION, 31'h7FFF_FFFF);
    write_reg(pcv_pkg::CFG_CHUNK_LIMIT, 31'd131071);
    random_phase(370);
    write_reg(pcv_pkg::CFG_MAX_DIMENSION, 31'($urandom_range(1, 64)));
    write_reg(pcv_pkg::CFG_CHUNK_LIMIT, 31'($urandom_range(2, 4)));
    random_phase(370);
    write_reg(pcv_pkg::CFG_MAX_DIMENSION, pcv_pkg::MAX_DIM_RESET);
    write_reg(pcv_pkg::CFG_CHUNK_LIMIT, 31'(pcv_pkg::CHUNK_LIM_RESET));
    // closing stretch runs with both sides always ready
    idle_en = 0;
    random_phase(370);
    repeat (10) @(posedge clk);

    $display("covered %0d byte beats in %0d candidate files, %0d verdicts checked",
             beats_sent, files_sent, verdicts_seen);
    $display("settings walked: reset defaults, smallest and largest limits, small random");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
